>>> src/lze_pkg.sv
// Shared types, constants and step codes for the Lorenz Euler stepper.
package lze_pkg;

    localparam int FRAC_BITS_DEF = 24;
    localparam int COORD_W       = 32;
    localparam int CFG_W         = 32;
    localparam int DT_W          = 31;
    localparam int IDX_W         = 3;
    localparam int MUL_W         = 33;
    localparam int PROD_W        = 2 * MUL_W;
    localparam int HI_SHIFT      = 32;
    localparam int CNT_W         = 4;

    localparam logic [COORD_W-1:0] COORD_MAX = 32'h7FFF_FFFF;
    localparam logic [COORD_W-1:0] COORD_MIN = 32'h8000_0000;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } t_state;

    typedef logic [CNT_W-1:0] t_step;

    localparam t_step STEP_SIG_DX = 4'd0;
    localparam t_step STEP_X_RZ   = 4'd1;
    localparam t_step STEP_XY     = 4'd2;
    localparam t_step STEP_BZ     = 4'd3;
    localparam t_step STEP_DTX_LO = 4'd4;
    localparam t_step STEP_DTX_HI = 4'd5;
    localparam t_step STEP_DTY_LO = 4'd6;
    localparam t_step STEP_DTY_HI = 4'd7;
    localparam t_step STEP_DTZ_LO = 4'd8;
    localparam t_step STEP_DTZ_HI = 4'd9;
    localparam t_step PIPE_LAT    = 4'd2;
    localparam t_step CNT_LAST    = t_step'(STEP_DTZ_HI + PIPE_LAT);

    typedef logic [IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_SIGMA   = 3'd0;
    localparam t_cfg_idx CFG_BETA    = 3'd1;
    localparam t_cfg_idx CFG_RHO     = 3'd2;
    localparam t_cfg_idx CFG_DT      = 3'd3;
    localparam t_cfg_idx CFG_START_X = 3'd4;
    localparam t_cfg_idx CFG_START_Y = 3'd5;
    localparam t_cfg_idx CFG_START_Z = 3'd6;

    typedef struct packed {
        logic signed [COORD_W-1:0] sigma;
        logic signed [COORD_W-1:0] beta;
        logic signed [COORD_W-1:0] rho;
        logic        [DT_W-1:0]    dt;
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] start_z;
    } t_cfg;

    typedef struct packed {
        logic  accept;
        logic  op_en;
        t_step op_step;
        logic  proc_en;
        t_step proc_step;
        logic  out_load;
    } t_ctrl;

endpackage

>>> src/lze_cfg.sv
// Configuration register file: Lorenz parameters, time step and start point.
module lze_cfg import lze_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  t_cfg_idx         i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    output t_cfg             o_cfg
);

    localparam logic [63:0] ONE_Q = 64'd1 << FRAC_BITS;
    localparam logic [COORD_W-1:0] SIGMA_RST = COORD_W'(64'd10 * ONE_Q);
    localparam logic [COORD_W-1:0] BETA_RST  =
        COORD_W'((64'd21666 * ONE_Q + 64'd5000) / 64'd10000);
    localparam logic [COORD_W-1:0] RHO_RST   = COORD_W'(64'd28 * ONE_Q);
    localparam logic [DT_W-1:0]    DT_RST    = DT_W'((ONE_Q + 64'd500) / 64'd1000);
    localparam logic [COORD_W-1:0] START_RST = COORD_W'(ONE_Q);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sigma   <= SIGMA_RST;
            r_cfg.beta    <= BETA_RST;
            r_cfg.rho     <= RHO_RST;
            r_cfg.dt      <= DT_RST;
            r_cfg.start_x <= START_RST;
            r_cfg.start_y <= START_RST;
            r_cfg.start_z <= START_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SIGMA:   r_cfg.sigma   <= i_cfg_data;
                CFG_BETA:    r_cfg.beta    <= i_cfg_data;
                CFG_RHO:     r_cfg.rho     <= i_cfg_data;
                CFG_DT:      r_cfg.dt      <= i_cfg_data[DT_W-1:0];
                CFG_START_X: r_cfg.start_x <= i_cfg_data;
                CFG_START_Y: r_cfg.start_y <= i_cfg_data;
                CFG_START_Z: r_cfg.start_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> src/lze_mul.sv
// Shared signed 33x33 multiplier with registered product.
module lze_mul import lze_pkg::*; (
    input  logic                     i_clk,
    input  logic signed [MUL_W-1:0]  i_a,
    input  logic signed [MUL_W-1:0]  i_b,
    output logic signed [PROD_W-1:0] o_prod
);

    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

>>> src/lze_ctrl.sv
// Step sequencer: request handshake, multiplier issue and result write-back timing.
module lze_ctrl import lze_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_out_free,
    output logic  o_in_ready,
    output t_ctrl o_ctrl
);

    t_state r_state, n_state;
    t_step  r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_ctrl     = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_ctrl.accept = 1'b1;
                    n_state       = ST_RUN;
                    n_cnt         = '0;
                end
            end
            ST_RUN: begin
                o_ctrl.op_en     = (r_cnt <= STEP_DTZ_HI);
                o_ctrl.op_step   = r_cnt;
                o_ctrl.proc_en   = (r_cnt >= PIPE_LAT);
                o_ctrl.proc_step = r_cnt - PIPE_LAT;
                if (r_cnt == CNT_LAST) begin
                    n_state = ST_DONE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_DONE: begin
                if (i_out_free) begin
                    o_ctrl.out_load = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

>>> src/lorenz_euler_stepper.sv
// Top level: Lorenz attractor Euler stepper around one shared multiplier.
// Each accepted request advances the stored point by one Euler step and returns the new
// point; with restart set the configured start point is loaded first. The ten products of
// a step (sigma*(y-x), x*(rho-z), x*y, beta*z, and dt times each derivative in two parts,
// its low 32 bits and the rest) go one per cycle through a single registered 33x33
// multiplier behind an operand register; each product passes the operand and product
// registers before it is written back, and the new point is then loaded into the result
// register once that is free. A new request is taken only after that load, back in the
// idle state, in which ready is high. Coordinates saturate at the signed 32-bit limits and flag
// it. The result register lets the next request start while the previous point waits to
// be taken. Ready is low while reset is held.
module lorenz_euler_stepper import lze_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_W-1:0]   i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_restart,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [COORD_W-1:0] o_pos_x,
    output logic [COORD_W-1:0] o_pos_y,
    output logic [COORD_W-1:0] o_pos_z,
    output logic               o_saturated
);

    localparam int D_W   = PROD_W - FRAC_BITS;
    localparam int ACC_W = D_W + HI_SHIFT;
    localparam int SUM_W = ACC_W + 1;
    localparam logic [COORD_W-1:0] ONE_RST = COORD_W'(64'd1 << FRAC_BITS);

    t_cfg  w_cfg;
    t_ctrl w_ctrl;
    logic  w_out_free;

    logic signed [COORD_W-1:0] r_cur_x, r_cur_y, r_cur_z;
    logic signed [D_W-1:0]     r_dx, r_dy, r_dz, r_m;
    logic signed [ACC_W-1:0]   r_acc;
    logic                      r_sat;
    logic signed [MUL_W-1:0]   r_opa, r_opb;
    logic signed [PROD_W-1:0]  w_prod;
    logic                      r_out_valid;
    logic [COORD_W-1:0]        r_pos_x, r_pos_y, r_pos_z;
    logic                      r_pos_sat;

    logic signed [MUL_W-1:0]        w_opa, w_opb, w_dt_op, w_d_lo, w_d_hi;
    logic signed [D_W-1:0]          w_d_sel;
    logic signed [D_W-HI_SHIFT-1:0] w_d_top;
    logic signed [PROD_W-1:0]       w_q;
    logic signed [D_W-1:0]          w_qd;
    logic signed [ACC_W-1:0]        w_prod_ext, w_sum, w_shq;
    logic signed [COORD_W-1:0]      w_old;
    logic signed [SUM_W-1:0]        w_new;
    logic [SUM_W-COORD_W:0]         w_top;
    logic                           w_clip;
    logic [COORD_W-1:0]             w_sat_val;

    lze_cfg #(
        .FRAC_BITS (FRAC_BITS)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    lze_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_free (w_out_free),
        .o_in_ready (o_in_ready),
        .o_ctrl     (w_ctrl)
    );

    lze_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (r_opa),
        .i_b    (r_opb),
        .o_prod (w_prod)
    );

    assign w_out_free = !r_out_valid || i_out_ready;

    // operand selection
    always_comb begin
        priority case (w_ctrl.op_step)
            STEP_DTX_LO, STEP_DTX_HI: w_d_sel = r_dx;
            STEP_DTY_LO, STEP_DTY_HI: w_d_sel = r_dy;
            default:                  w_d_sel = r_dz;
        endcase
    end

    assign w_dt_op = MUL_W'(w_cfg.dt);
    assign w_d_lo  = {1'b0, w_d_sel[HI_SHIFT-1:0]};
    assign w_d_top = w_d_sel[D_W-1:HI_SHIFT];
    assign w_d_hi  = MUL_W'(w_d_top);

    always_comb begin
        w_opa = '0;
        w_opb = '0;
        unique case (w_ctrl.op_step)
            STEP_SIG_DX: begin
                w_opa = MUL_W'(w_cfg.sigma);
                w_opb = MUL_W'(r_cur_y) - MUL_W'(r_cur_x);
            end
            STEP_X_RZ: begin
                w_opa = MUL_W'(r_cur_x);
                w_opb = MUL_W'(w_cfg.rho) - MUL_W'(r_cur_z);
            end
            STEP_XY: begin
                w_opa = MUL_W'(r_cur_x);
                w_opb = MUL_W'(r_cur_y);
            end
            STEP_BZ: begin
                w_opa = MUL_W'(w_cfg.beta);
                w_opb = MUL_W'(r_cur_z);
            end
            STEP_DTX_LO, STEP_DTY_LO, STEP_DTZ_LO: begin
                w_opa = w_dt_op;
                w_opb = w_d_lo;
            end
            STEP_DTX_HI, STEP_DTY_HI, STEP_DTZ_HI: begin
                w_opa = w_dt_op;
                w_opb = w_d_hi;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.op_en) begin
            r_opa <= w_opa;
            r_opb <= w_opb;
        end
    end

    // product post-processing: floor shift, split-product sum, update and clip
    assign w_q        = w_prod >>> FRAC_BITS;
    assign w_qd       = w_q[D_W-1:0];
    assign w_prod_ext = ACC_W'(w_prod);
    assign w_sum      = r_acc + (w_prod_ext <<< HI_SHIFT);
    assign w_shq      = w_sum >>> FRAC_BITS;

    always_comb begin
        priority case (w_ctrl.proc_step)
            STEP_DTX_HI: w_old = r_cur_x;
            STEP_DTY_HI: w_old = r_cur_y;
            default:     w_old = r_cur_z;
        endcase
    end

    assign w_new     = SUM_W'(w_old) + SUM_W'(w_shq);
    assign w_top     = w_new[SUM_W-1:COORD_W-1];
    assign w_clip    = !((&w_top) || !(|w_top));
    assign w_sat_val = w_clip ? (w_new[SUM_W-1] ? COORD_MIN : COORD_MAX)
                              : w_new[COORD_W-1:0];

    always_ff @(posedge i_clk) begin
        if (w_ctrl.proc_en) begin
            unique case (w_ctrl.proc_step)
                STEP_SIG_DX: r_dx <= w_qd;
                STEP_X_RZ:   r_dy <= w_qd - D_W'(r_cur_y);
                STEP_XY:     r_m  <= w_qd;
                STEP_BZ:     r_dz <= r_m - w_qd;
                STEP_DTX_LO, STEP_DTY_LO, STEP_DTZ_LO: r_acc <= w_prod_ext;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x <= ONE_RST;
            r_cur_y <= ONE_RST;
            r_cur_z <= ONE_RST;
            r_sat   <= 1'b0;
        end else if (w_ctrl.accept) begin
            r_sat <= 1'b0;
            if (i_restart) begin
                r_cur_x <= w_cfg.start_x;
                r_cur_y <= w_cfg.start_y;
                r_cur_z <= w_cfg.start_z;
            end
        end else if (w_ctrl.proc_en) begin
            unique case (w_ctrl.proc_step)
                STEP_DTX_HI: begin
                    r_cur_x <= w_sat_val;
                    r_sat   <= r_sat | w_clip;
                end
                STEP_DTY_HI: begin
                    r_cur_y <= w_sat_val;
                    r_sat   <= r_sat | w_clip;
                end
                STEP_DTZ_HI: begin
                    r_cur_z <= w_sat_val;
                    r_sat   <= r_sat | w_clip;
                end
                default: ;
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctrl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.out_load) begin
            r_pos_x   <= r_cur_x;
            r_pos_y   <= r_cur_y;
            r_pos_z   <= r_cur_z;
            r_pos_sat <= r_sat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pos_x     = r_pos_x;
    assign o_pos_y     = r_pos_y;
    assign o_pos_z     = r_pos_z;
    assign o_saturated = r_pos_sat;

endmodule

>>> src/lze_checker.sv
// Port-level assertions for the Lorenz Euler stepper, bound to the top level.
module lze_checker import lze_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic [COORD_W-1:0] o_pos_x,
    input logic [COORD_W-1:0] o_pos_y,
    input logic [COORD_W-1:0] o_pos_z,
    input logic               o_saturated
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_pos_x)
            && $stable(o_pos_y) && $stable(o_pos_z) && $stable(o_saturated)))
        else $error("stalled result changed");

    // one request at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready right after accept");

    // a new result only comes out of a busy period
    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result without work");

    // saturation flag implies a clipped coordinate
    a_sat_clipped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_saturated) |->
            (o_pos_x == COORD_MAX || o_pos_x == COORD_MIN ||
             o_pos_y == COORD_MAX || o_pos_y == COORD_MIN ||
             o_pos_z == COORD_MAX || o_pos_z == COORD_MIN))
        else $error("saturated without a clipped coordinate");

endmodule

bind lorenz_euler_stepper lze_checker u_lze_checker (.*);
